[sv/aspe_pkg.sv]
// Shared types and constants of the adjacency shortest-path engine.
// No dependencies; the other files, aspe_mem apart, refer to it by scoped names.
`default_nettype none
package aspe_pkg;

  localparam int NODE_W   = 6;   // node index field width
  localparam int CMD_W    = 3;
  localparam int CNT_W    = 7;   // node_count and degree width
  localparam int STATUS_W = 2;
  localparam int DIST_W   = 7;

  localparam logic [DIST_W-1:0] DIST_UNREACHED = '1;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FILL  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_EDGE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PATH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REG   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EDGE_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNREACHED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NODE_RANGE = 2'd3;

  // distance update in every cell
  typedef enum logic [1:0] {
    DOP_HOLD,
    DOP_INIT,
    DOP_RELAX
  } dist_op_t;

  // shift-bit update in every cell
  typedef enum logic [2:0] {
    SOP_HOLD,
    SOP_LOAD_LVL,
    SOP_LOAD_CAND,
    SOP_LOAD_ROW,
    SOP_SHIFT
  } shift_op_t;

  typedef struct packed {
    dist_op_t           dop;
    shift_op_t          sop;
    logic [DIST_W-1:0]  lvl;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[sv/aspe_if.sv]
// Valid/ready channel interfaces of the engine: request, response, config.
// Depends on aspe_pkg for field widths.
`default_nettype none
interface aspe_req_if;
  logic                         valid;
  logic                         ready;
  logic [aspe_pkg::CMD_W-1:0]   cmd;
  logic [aspe_pkg::NODE_W-1:0]  node_a;
  logic [aspe_pkg::NODE_W-1:0]  node_b;
  logic [aspe_pkg::CNT_W-1:0]   degree;
  modport source (output valid, cmd, node_a, node_b, degree, input ready);
  modport sink   (input valid, cmd, node_a, node_b, degree, output ready);
endinterface

interface aspe_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [aspe_pkg::NODE_W-1:0]    path_node;
  logic                           node_valid;
  logic                           last;
  logic [aspe_pkg::STATUS_W-1:0]  status;
  logic                           is_regular;
  modport source (output valid, path_node, node_valid, last, status, is_regular,
                  input ready);
  modport sink   (input valid, path_node, node_valid, last, status, is_regular,
                  output ready);
endinterface

interface aspe_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [aspe_pkg::CNT_W-1:0]  node_count;
  modport source (output valid, node_count, input ready);
  modport sink   (input valid, node_count, output ready);
endinterface
`default_nettype wire

[sv/adjacency_shortest_path_engine.sv]
// Adjacency shortest-path engine top level: command sequencer, node cells,
// matrix memory. Depends on aspe_pkg, aspe_if, aspe_cell, aspe_mem.
//
// One request beat at a time. Clear, set-all and unused codes answer
// directly, an edge add after two read-modify-writes of matrix rows.
// A path query runs a breadth-first search: each distance level is one
// sweep, where the single matrix read port fetches one row a cycle
// while match bits shift down the cell chain; the search ends at the
// level that holds the destination, or as unreached at an empty level.
// Each backtrack hop is a row read, then a serial scan of the chain for
// the lowest predecessor. A regularity check reads each row and counts
// its bits serially. No clearing pass after reset; the response register
// lets a new request be taken while the last response beat waits.
`default_nettype none
module adjacency_shortest_path_engine #(
  parameter int MAX_NODES = 64
) (
  input  wire             clk,
  input  wire             rst,
  aspe_cfg_if.sink        cfg,
  aspe_req_if.sink        req,
  aspe_rsp_if.source      rsp
);

  localparam int LIMIT = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int AW    = $clog2(LIMIT);
  localparam int NW    = aspe_pkg::NODE_W;
  localparam int CW    = aspe_pkg::CNT_W;
  localparam int DW    = aspe_pkg::DIST_W;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_EDGE_A   = 16'h0002,
    S_EDGE_AW  = 16'h0004,
    S_EDGE_B   = 16'h0008,
    S_EDGE_BW  = 16'h0010,
    S_INIT     = 16'h0020,
    S_SNAP     = 16'h0040,
    S_SWEEP    = 16'h0080,
    S_DRAIN    = 16'h0100,
    S_BT_RD    = 16'h0200,
    S_BT_LOAD  = 16'h0400,
    S_BT_SCAN  = 16'h0800,
    S_REG_RD   = 16'h1000,
    S_REG_LOAD = 16'h2000,
    S_REG_SCAN = 16'h4000,
    S_RESP     = 16'h8000
  } state_t;

  state_t state;

  logic [CW-1:0] n_eff;
  logic [NW-1:0] a_q, b_q;
  logic [CW-1:0] deg_q;
  logic [AW-1:0] k, endn, r;
  logic [DW-1:0] lvl;
  logic [CW-1:0] cnt;
  logic          seen, rel_pend;

  logic [NW-1:0]              resp_node;
  logic                       resp_valid, resp_last, resp_reg;
  logic [aspe_pkg::STATUS_W-1:0] resp_status;

  logic                       ov;
  logic [NW-1:0]              o_node;
  logic                       o_valid, o_last, o_reg;
  logic [aspe_pkg::STATUS_W-1:0] o_status;

  logic            acc, cfg_wr, emit, head, k_last, r_last;
  logic [CW-1:0]   tot;
  logic [CW-1:0]   cfg_clamped;

  logic [AW-1:0]    rd_addr, wr_addr;
  logic [LIMIT-1:0] rd_row, wr_row;
  logic             wr_en, fill_en, fill_val;

  aspe_pkg::cell_ctrl_t ctrl;
  logic [LIMIT:0]       sh;

  assign acc    = req.valid && req.ready;
  assign cfg_wr = cfg.valid && cfg.ready;
  assign emit   = (state == S_RESP) && (!ov || rsp.ready);
  assign head   = sh[0];
  assign k_last = (CW'(k) == n_eff - CW'(1));
  assign r_last = (CW'(r) == n_eff - CW'(1));
  assign tot    = cnt + CW'(head);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    if (cfg.node_count == '0) begin
      cfg_clamped = CW'(1);
    end else if (cfg.node_count > CW'(LIMIT)) begin
      cfg_clamped = CW'(LIMIT);
    end else begin
      cfg_clamped = cfg.node_count;
    end
  end

  // matrix port control
  always_comb begin
    unique case (state)
      S_EDGE_A: rd_addr = a_q[AW-1:0];
      S_EDGE_B: rd_addr = b_q[AW-1:0];
      S_BT_RD:  rd_addr = endn;
      S_REG_RD: rd_addr = r;
      default:  rd_addr = k;
    endcase
    wr_en   = (state == S_EDGE_AW) || (state == S_EDGE_BW);
    wr_addr = (state == S_EDGE_AW) ? a_q[AW-1:0] : b_q[AW-1:0];
    wr_row  = (state == S_EDGE_AW) ? (rd_row | (LIMIT'(1) << b_q[AW-1:0]))
                                   : (rd_row | (LIMIT'(1) << a_q[AW-1:0]));
    fill_en  = cfg_wr;
    fill_val = 1'b1;
    if (acc && !cfg_wr) begin
      if (req.cmd == aspe_pkg::CMD_CLEAR) begin
        fill_en  = 1'b1;
        fill_val = 1'b0;
      end else if (req.cmd == aspe_pkg::CMD_FILL) begin
        fill_en = 1'b1;
      end else if (req.cmd == aspe_pkg::CMD_EDGE &&
                   ({1'b0, req.node_a} >= n_eff || {1'b0, req.node_b} >= n_eff)) begin
        fill_en = 1'b1;
      end
    end
  end

  // cell chain control
  always_comb begin
    ctrl.lvl = lvl;
    if (state == S_INIT) begin
      ctrl.dop = aspe_pkg::DOP_INIT;
    end else if (rel_pend) begin
      ctrl.dop = aspe_pkg::DOP_RELAX;
    end else begin
      ctrl.dop = aspe_pkg::DOP_HOLD;
    end
    unique case (state)
      S_SNAP:     ctrl.sop = aspe_pkg::SOP_LOAD_LVL;
      S_BT_LOAD:  ctrl.sop = aspe_pkg::SOP_LOAD_CAND;
      S_REG_LOAD: ctrl.sop = aspe_pkg::SOP_LOAD_ROW;
      S_SWEEP, S_BT_SCAN, S_REG_SCAN: ctrl.sop = aspe_pkg::SOP_SHIFT;
      default:    ctrl.sop = aspe_pkg::SOP_HOLD;
    endcase
  end

  assign sh[LIMIT] = 1'b0;

  for (genvar i = 0; i < LIMIT; i++) begin : g_cell
    aspe_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .row_bit   (rd_row[i]),
      .active    (CW'(i) < n_eff),
      .is_src    (a_q == NW'(i)),
      .shift_in  (sh[i+1]),
      .shift_bit (sh[i])
    );
  end

  aspe_mem #(
    .ROWS (LIMIT),
    .AW   (AW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_row   (rd_row),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_row   (wr_row),
    .fill_en  (fill_en),
    .fill_val (fill_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      n_eff    <= CW'(LIMIT);
      ov       <= 1'b0;
      rel_pend <= 1'b0;
    end else begin
      if (cfg_wr) begin
        n_eff <= cfg_clamped;
      end
      if (emit) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
      rel_pend <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            a_q         <= req.node_a;
            b_q         <= req.node_b;
            deg_q       <= req.degree;
            resp_node   <= '0;
            resp_valid  <= 1'b0;
            resp_last   <= 1'b1;
            resp_status <= aspe_pkg::ST_OK;
            resp_reg    <= 1'b0;
            state       <= S_RESP;
            unique case (req.cmd)
              aspe_pkg::CMD_EDGE: begin
                if ({1'b0, req.node_a} >= n_eff || {1'b0, req.node_b} >= n_eff) begin
                  resp_status <= aspe_pkg::ST_EDGE_RANGE;
                end else begin
                  state <= S_EDGE_A;
                end
              end
              aspe_pkg::CMD_PATH: begin
                if ({1'b0, req.node_a} >= n_eff || {1'b0, req.node_b} >= n_eff) begin
                  resp_status <= aspe_pkg::ST_NODE_RANGE;
                end else if (req.node_a != req.node_b) begin
                  state <= S_INIT;
                end
              end
              aspe_pkg::CMD_REG: begin
                if (!(n_eff[0] && req.degree[0])) begin
                  r     <= '0;
                  state <= S_REG_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_EDGE_A:  state <= S_EDGE_AW;
        S_EDGE_AW: state <= S_EDGE_B;
        S_EDGE_B:  state <= S_EDGE_BW;
        S_EDGE_BW: state <= S_RESP;
        S_INIT: begin
          lvl   <= '0;
          state <= S_SNAP;
        end
        S_SNAP: begin
          k     <= '0;
          seen  <= 1'b0;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          seen <= seen || head;
          if (head && CW'(k) == {1'b0, b_q}) begin
            // destination sits on this level
            endn <= b_q[AW-1:0];
            state <= (lvl == DW'(1)) ? S_RESP : S_BT_RD;
          end else begin
            rel_pend <= head;
            k <= k + 1'b1;
            if (k_last) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (!seen) begin
            resp_status <= aspe_pkg::ST_UNREACHED;
            state       <= S_RESP;
          end else begin
            lvl   <= lvl + 1'b1;
            state <= S_SNAP;
          end
        end
        S_BT_RD: begin
          lvl   <= lvl - 1'b1;
          state <= S_BT_LOAD;
        end
        S_BT_LOAD: begin
          k     <= '0;
          state <= S_BT_SCAN;
        end
        S_BT_SCAN: begin
          if (head) begin
            resp_node  <= NW'(k);
            resp_valid <= 1'b1;
            resp_last  <= (lvl == DW'(1));
            endn       <= k;
            state      <= S_RESP;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_REG_RD:  state <= S_REG_LOAD;
        S_REG_LOAD: begin
          k     <= '0;
          cnt   <= '0;
          state <= S_REG_SCAN;
        end
        S_REG_SCAN: begin
          cnt <= tot;
          k   <= k + 1'b1;
          if (k_last) begin
            if (tot != deg_q) begin
              state <= S_RESP;
            end else if (r_last) begin
              resp_reg <= 1'b1;
              state    <= S_RESP;
            end else begin
              r     <= r + 1'b1;
              state <= S_REG_RD;
            end
          end
        end
        S_RESP: begin
          if (emit) begin
            state <= resp_last ? S_IDLE : S_BT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_node   <= resp_node;
      o_valid  <= resp_valid;
      o_last   <= resp_last;
      o_status <= resp_status;
      o_reg    <= resp_reg;
    end
  end

  assign rsp.valid      = ov;
  assign rsp.path_node  = o_node;
  assign rsp.node_valid = o_valid;
  assign rsp.last       = o_last;
  assign rsp.status     = o_status;
  assign rsp.is_regular = o_reg;

endmodule
`default_nettype wire

[sv/aspe_cell.sv]
// One node cell of the chain: hop distance plus one shift bit passed to
// the lower neighbor. Depends on aspe_pkg.
`default_nettype none
module aspe_cell (
  input  wire                     clk,
  input  aspe_pkg::cell_ctrl_t    ctrl,
  input  wire                     row_bit,
  input  wire                     active,
  input  wire                     is_src,
  input  wire                     shift_in,
  output logic                    shift_bit
);

  logic [aspe_pkg::DIST_W-1:0] hops;
  logic                        lvl_hit;

  assign lvl_hit = active && (hops == ctrl.lvl);

  always_ff @(posedge clk) begin
    unique case (ctrl.dop)
      aspe_pkg::DOP_INIT: begin
        hops <= is_src ? '0 : aspe_pkg::DIST_UNREACHED;
      end
      aspe_pkg::DOP_RELAX: begin
        if (row_bit && active && hops == aspe_pkg::DIST_UNREACHED) begin
          hops <= ctrl.lvl + 1'b1;
        end
      end
      default: begin
      end
    endcase

    unique case (ctrl.sop)
      aspe_pkg::SOP_LOAD_LVL:  shift_bit <= lvl_hit;
      aspe_pkg::SOP_LOAD_CAND: shift_bit <= lvl_hit && row_bit;
      aspe_pkg::SOP_LOAD_ROW:  shift_bit <= active && row_bit;
      aspe_pkg::SOP_SHIFT:     shift_bit <= shift_in;
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/aspe_mem.sv]
// Adjacency matrix row memory with per-row valid bits and a common fill
// value, so clear and set-all need no pass over the rows. No dependencies.
`default_nettype none
module aspe_mem #(
  parameter int ROWS = 64,
  parameter int AW   = 6
) (
  input  wire             clk,
  input  wire             rst,
  input  wire  [AW-1:0]   rd_addr,
  output logic [ROWS-1:0] rd_row,
  input  wire             wr_en,
  input  wire  [AW-1:0]   wr_addr,
  input  wire  [ROWS-1:0] wr_row,
  input  wire             fill_en,
  input  wire             fill_val
);

  logic [ROWS-1:0] mem [ROWS];
  logic [ROWS-1:0] rd_data;
  logic [AW-1:0]   rd_addr_q;
  logic [ROWS-1:0] vld;
  logic            fillv;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_data   <= mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      fillv <= 1'b1;
    end else if (fill_en) begin
      vld   <= '0;
      fillv <= fill_val;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // rows never written since the last fill read as the fill value
  assign rd_row = vld[rd_addr_q] ? rd_data : {ROWS{fillv}};

endmodule
`default_nettype wire

[verif/aspe_checker.sv]
// Checker for the adjacency shortest-path engine: predicts result beats from
// accepted request and config beats and compares them. Depends on aspe_pkg, aspe_if.
`timescale 1ns / 1ps
module aspe_checker (
  input  wire     clk,
  input  wire     rst,
  aspe_cfg_if     cfg,
  aspe_req_if     req,
  aspe_rsp_if     rsp,
  output int      fail_count,
  output int      pending
);

  typedef struct packed {
    logic [aspe_pkg::NODE_W-1:0]   path_node;
    logic                          node_valid;
    logic                          last;
    logic [aspe_pkg::STATUS_W-1:0] status;
    logic                          is_regular;
  } beat_t;

  logic [63:0] adj [64];
  int unsigned active_n;
  beat_t expected_beats[$];

  function automatic beat_t mk(logic [5:0] nd, logic v, logic l, logic [1:0] st, logic r);
    beat_t b;
    b.path_node = nd; b.node_valid = v; b.last = l; b.status = st; b.is_regular = r;
    return b;
  endfunction

  function automatic void queue_beat(logic [5:0] nd, logic v, logic l, logic [1:0] st,
                                     logic r);
    expected_beats = {expected_beats, mk(nd, v, l, st, r)};
  endfunction

  task automatic fill_matrix(logic bitv);
    for (int i = 0; i < 64; i++) adj[i] = {64{bitv}};
  endtask

  task automatic predict_path(int unsigned s, int unsigned d);
    int hop_d [64];
    bit seen [64];
    int path_nodes [64];
    int best, bi, w, cur, cnt;
    bit found, step;
    if (s >= active_n || d >= active_n) begin
      queue_beat(6'd0, 1'b0, 1'b1, aspe_pkg::ST_NODE_RANGE, 1'b0);
      return;
    end
    if (s == d) begin
      queue_beat(6'd0, 1'b0, 1'b1, aspe_pkg::ST_OK, 1'b0);
      return;
    end
    for (int i = 0; i < 64; i++) begin hop_d[i] = -1; seen[i] = 0; end
    hop_d[s] = 0;
    forever begin
      found = 0; best = 0; bi = 0;
      for (int i = 0; i < active_n; i++)
        if (!seen[i] && hop_d[i] >= 0 && (!found || hop_d[i] < best)) begin
          best = hop_d[i]; bi = i; found = 1;
        end
      if (!found) break;
      for (int i = 0; i < active_n; i++)
        if (adj[bi][i] && (hop_d[i] < 0 || best + 1 < hop_d[i])) hop_d[i] = best + 1;
      seen[bi] = 1;
    end
    if (hop_d[d] < 0) begin
      queue_beat(6'd0, 1'b0, 1'b1, aspe_pkg::ST_UNREACHED, 1'b0);
      return;
    end
    cur = d; w = hop_d[d]; cnt = 0;
    while (cur != s && w > 0) begin
      step = 0;
      for (int i = 0; i < active_n; i++)
        if (adj[cur][i] && hop_d[i] == w - 1) begin
          cur = i; w--; step = 1; break;
        end
      if (!step) break;
      if (cur != s && cnt < 64) begin
        path_nodes[cnt] = cur;
        cnt++;
      end
    end
    if (cnt == 0) queue_beat(6'd0, 1'b0, 1'b1, aspe_pkg::ST_OK, 1'b0);
    for (int i = 0; i < cnt; i++)
      queue_beat(6'(path_nodes[i]), 1'b1, i + 1 == cnt, aspe_pkg::ST_OK, 1'b0);
  endtask

  function automatic logic regular(int unsigned deg);
    int c;
    if (active_n[0] && deg[0]) return 0;
    for (int i = 0; i < active_n; i++) begin
      c = 0;
      for (int j = 0; j < active_n; j++) c += adj[i][j];
      if (c != deg) return 0;
    end
    return 1;
  endfunction

  task automatic predict_cmd(logic [2:0] c, int unsigned a, int unsigned b,
                             int unsigned deg);
    unique case (c)
      aspe_pkg::CMD_CLEAR: begin
        fill_matrix(0);
        queue_beat(6'd0, 1'b0, 1'b1, aspe_pkg::ST_OK, 1'b0);
      end
      aspe_pkg::CMD_FILL: begin
        fill_matrix(1);
        queue_beat(6'd0, 1'b0, 1'b1, aspe_pkg::ST_OK, 1'b0);
      end
      aspe_pkg::CMD_EDGE: begin
        if (a >= active_n || b >= active_n) begin
          fill_matrix(1);
          queue_beat(6'd0, 1'b0, 1'b1, aspe_pkg::ST_EDGE_RANGE, 1'b0);
        end else begin
          adj[a][b] = 1; adj[b][a] = 1;
          queue_beat(6'd0, 1'b0, 1'b1, aspe_pkg::ST_OK, 1'b0);
        end
      end
      aspe_pkg::CMD_PATH: predict_path(a, b);
      aspe_pkg::CMD_REG:  queue_beat(6'd0, 1'b0, 1'b1, aspe_pkg::ST_OK, regular(deg));
      default:            queue_beat(6'd0, 1'b0, 1'b1, aspe_pkg::ST_OK, 1'b0);
    endcase
  endtask

  always @(posedge clk) begin
    beat_t got, want;
    if (rst) begin
      fill_matrix(1);
      active_n = 64;
      fail_count = 0;
      expected_beats.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        active_n = cfg.node_count == 0 ? 1 : (cfg.node_count > 64 ? 64 : cfg.node_count);
        fill_matrix(1);
      end
      if (req.valid && req.ready)
        predict_cmd(req.cmd, req.node_a, req.node_b, req.degree);
      if (rsp.valid && rsp.ready) begin
        got = mk(rsp.path_node, rsp.node_valid, rsp.last, rsp.status, rsp.is_regular);
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected node=%0d v=%0d last=%0d st=%0d reg=%0d",
                     $time, want.path_node, want.node_valid, want.last, want.status,
                     want.is_regular);
            $display("%0t:          actual node=%0d v=%0d last=%0d st=%0d reg=%0d",
                     $time, got.path_node, got.node_valid, got.last, got.status,
                     got.is_regular);
            fail_count++;
          end
        end
      end
    end
    pending = expected_beats.size();
  end
endmodule

[verif/tb_top.sv]
// Top of the shortest-path engine testbench: clock, reset, stimulus, verdict.
// Depends on aspe_pkg, aspe_if, aspe_checker and the engine RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG = 400000;
  // command codes the engine leaves unused
  localparam logic [2:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  logic clk = 0;
  logic rst = 1;
  int   fails, pending;
  int   send_idle = 33, recv_idle = 50;
  int   idle_cycles;
  int   cur_n = 64;

  aspe_cfg_if cfg();
  aspe_req_if req();
  aspe_rsp_if rsp();

  adjacency_shortest_path_engine dut (.clk(clk), .rst(rst), .cfg(cfg), .req(req), .rsp(rsp));
  aspe_checker u_checker (.clk(clk), .rst(rst), .cfg(cfg), .req(req), .rsp(rsp),
                          .fail_count(fails), .pending(pending));

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    cfg.valid = 0; cfg.node_count = 0;
    req.valid = 0; req.cmd = 0; req.node_a = 0; req.node_b = 0; req.degree = 0;
    rsp.ready = 0;
  end

  always @(posedge clk)
    rsp.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  // valid stays high into the next beat unless the sender idles
  task automatic send(logic [2:0] c, logic [5:0] a, logic [5:0] b, logic [6:0] deg);
    if ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    req.valid <= 1'b1; req.cmd <= c; req.node_a <= a; req.node_b <= b; req.degree <= deg;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic set_nodes(logic [6:0] v);
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg.valid <= 1'b1; cfg.node_count <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    cur_n = v == 0 ? 1 : (v > 64 ? 64 : v);
  endtask

  // sparse random graph mixed with queries; mostly in range
  task automatic random_phase(int items);
    int k;
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(99);
      if (k < 40)
        send(aspe_pkg::CMD_EDGE, 6'($urandom_range(cur_n - 1)),
             6'($urandom_range(cur_n - 1)), 7'd0);
      else if (k < 75)
        send(aspe_pkg::CMD_PATH, 6'($urandom_range(cur_n - 1)),
             6'($urandom_range(cur_n - 1)), 7'd0);
      else if (k < 82)
        send(k[0] ? aspe_pkg::CMD_PATH : aspe_pkg::CMD_EDGE, 6'($urandom), 6'($urandom),
             7'd0);
      else if (k < 88)
        send(aspe_pkg::CMD_REG, 6'd0, 6'd0, 7'($urandom_range(k[0] ? 127 : 4)));
      else if (k < 92)
        send(aspe_pkg::CMD_CLEAR, 6'($urandom), 6'($urandom), 7'($urandom));
      else if (k < 94)
        send(aspe_pkg::CMD_FILL, 6'($urandom), 6'($urandom), 7'($urandom));
      else if (k < 96)
        send(3'($urandom_range(CMD_UNUSED_7, CMD_UNUSED_5)), 6'($urandom), 6'($urandom),
             7'($urandom));
      else
        send(aspe_pkg::CMD_CLEAR, 6'd0, 6'd0, 7'd0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: default size, all ones
    send(aspe_pkg::CMD_REG, 6'd0, 6'd0, 7'd64);
    send(aspe_pkg::CMD_PATH, 6'd0, 6'd63, 7'd0);
    send(aspe_pkg::CMD_PATH, 6'd5, 6'd5, 7'd0);
    send(aspe_pkg::CMD_EDGE, 6'd63, 6'd0, 7'd0);
    send(CMD_UNUSED_5, 6'd63, 6'd63, 7'd127);
    send(CMD_UNUSED_6, 6'd0, 6'd0, 7'd0);
    send(CMD_UNUSED_7, 6'd1, 6'd2, 7'd3);
    send(aspe_pkg::CMD_CLEAR, 6'd0, 6'd0, 7'd0);
    send(aspe_pkg::CMD_PATH, 6'd0, 6'd63, 7'd0);
    for (int i = 0; i < 6; i++) send(aspe_pkg::CMD_EDGE, 6'(i), 6'(i + 1), 7'd0);
    send(aspe_pkg::CMD_PATH, 6'd6, 6'd0, 7'd0);
    send(aspe_pkg::CMD_PATH, 6'd0, 6'd1, 7'd0);
    send(aspe_pkg::CMD_REG, 6'd0, 6'd0, 7'd0);
    set_nodes(7'd5);
    send(aspe_pkg::CMD_EDGE, 6'd2, 6'd5, 7'd0);
    send(aspe_pkg::CMD_PATH, 6'd0, 6'd6, 7'd0);
    send(aspe_pkg::CMD_REG, 6'd0, 6'd0, 7'd5);
    send(aspe_pkg::CMD_REG, 6'd0, 6'd0, 7'd3);
    send(aspe_pkg::CMD_CLEAR, 6'd0, 6'd0, 7'd0);
    send(aspe_pkg::CMD_EDGE, 6'd0, 6'd0, 7'd0);
    set_nodes(7'd0);
    send(aspe_pkg::CMD_PATH, 6'd0, 6'd0, 7'd0);
    send(aspe_pkg::CMD_REG, 6'd0, 6'd0, 7'd1);
    set_nodes(7'd127);
    send(aspe_pkg::CMD_REG, 6'd0, 6'd0, 7'd64);

    set_nodes(7'd12);
    send(aspe_pkg::CMD_CLEAR, 6'd0, 6'd0, 7'd0);
    random_phase(100);
    send_idle = 50; recv_idle = 33;
    set_nodes(7'd64);
    send(aspe_pkg::CMD_CLEAR, 6'd0, 6'd0, 7'd0);
    // long chain for a many-node path
    for (int i = 0; i < 63; i++) send(aspe_pkg::CMD_EDGE, 6'(i), 6'(i + 1), 7'd0);
    send(aspe_pkg::CMD_PATH, 6'd63, 6'd0, 7'd0);
    send(aspe_pkg::CMD_PATH, 6'd0, 6'd63, 7'd0);
    random_phase(40);
    send_idle = 0; recv_idle = 0;
    set_nodes(7'($urandom_range(2, 20)));
    send(aspe_pkg::CMD_CLEAR, 6'd0, 6'd0, 7'd0);
    random_phase(90);

    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
